// File: hdl/pcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_pkg
// shared types, widths and saturation helpers for the plane collider core
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int POS_W      = 21;
    localparam int VEL_W      = 32;
    localparam int NRM_W      = 16;
    localparam int FC_W       = 16;
    localparam int SQ_W       = 64;
    localparam int DROP_W     = 38;
    localparam int SPD_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TDATA_W    = 160;
    localparam int REGION_EPS = 1100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL   = 3'd0,
        CFG_OFFSET   = 3'd1,
        CFG_FRICTION = 3'd2,
        CFG_REGION   = 3'd3,
        CFG_LOW      = 3'd4,
        CFG_HIGH     = 3'd5,
        CFG_SLOP     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [47:0]             normal;
        logic signed [POS_W-1:0] offset;
        logic [FC_W-1:0]         fc;
        logic                    region_en;
        logic [62:0]             low;
        logic [62:0]             high;
        logic signed [POS_W-1:0] slop;
    } t_cfg;

    // classified item handed from front to back
    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [2:0][VEL_W-1:0] vel;
        logic [2:0][VEL_W-1:0] tang;
        logic [SQ_W-1:0]       sq;
        logic [DROP_W-1:0]     drop;
        logic                  in_reg;
        logic                  contact;
        logic                  zero;
    } t_front_res;

    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [38:0] v);
        logic signed [38:0] hi;
        logic signed [38:0] lo;
        hi = 39'sd2147483647;
        lo = -39'sd2147483648;
        if (v > hi) begin
            return 32'h7FFF_FFFF;
        end else if (v < lo) begin
            return 32'h8000_0000;
        end
        return v[VEL_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [29:0] v);
        logic signed [29:0] hi;
        logic signed [29:0] lo;
        hi = 30'sd1048575;
        lo = -30'sd1048576;
        if (v > hi) begin
            return 21'h0F_FFFF;
        end else if (v < lo) begin
            return 21'h10_0000;
        end
        return v[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: hdl/pcf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_front
// six-stage geometry pipeline: distance, projection, region, tangent, flags
// ----------------------------------------------------------------------------
module pcf_front import pcf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_type,
    input  wire logic [2:0][POS_W-1:0] i_pos,
    input  wire logic [2:0][VEL_W-1:0] i_vel,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_front_res                 o_res
);

    logic signed [NRM_W-1:0] w_n  [3];
    logic signed [57:0]      w_lo [3];
    logic signed [57:0]      w_hi [3];
    logic                    w_en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_n[i]  = $signed(i_cfg.normal[16*i +: 16]);
            w_lo[i] = 58'($signed(i_cfg.low[21*i +: 21])) <<< 28;
            w_hi[i] = 58'($signed(i_cfg.high[21*i +: 21])) <<< 28;
        end
    end

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage 1: per-axis products
    logic                  r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic                  r1_type, r2_type, r3_type, r4_type;
    logic [2:0][POS_W-1:0] r1_p, r2_p, r3_p, r4_p, r5_p;
    logic [2:0][VEL_W-1:0] r1_vel, r2_vel, r3_vel, r4_vel, r5_vel, r6_vel;
    logic signed [36:0]    r1_pn [3];
    logic signed [47:0]    r1_vn [3];
    logic signed [36:0]    n1_pn [3];
    logic signed [47:0]    n1_vn [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_pn[i] = $signed(i_pos[i]) * w_n[i];
            n1_vn[i] = $signed(i_vel[i]) * w_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_type <= i_type;
            r1_p    <= i_pos;
            r1_vel  <= i_vel;
            r1_pn   <= n1_pn;
            r1_vn   <= n1_vn;
        end
    end

    // stage 2: distance and normal speed
    logic signed [39:0] r2_d, n2_d;
    logic signed [49:0] r2_vn, n2_vn;

    assign n2_d  = 40'(r1_pn[0]) + 40'(r1_pn[1]) + 40'(r1_pn[2])
                 - (40'(i_cfg.offset) <<< 14);
    assign n2_vn = 50'(r1_vn[0]) + 50'(r1_vn[1]) + 50'(r1_vn[2]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_type <= r1_type;
            r2_p    <= r1_p;
            r2_vel  <= r1_vel;
            r2_d    <= n2_d;
            r2_vn   <= n2_vn;
        end
    end

    // stage 3: scale normal by distance and by rounded normal speed
    logic signed [49:0] w3_vnr;
    logic signed [35:0] w3_vn16;
    logic signed [36:0] w3_neg;
    logic signed [55:0] n3_dn  [3];
    logic signed [51:0] n3_vnn [3];
    logic signed [55:0] r3_dn  [3];
    logic signed [51:0] r3_vnn [3];
    logic [33:0]        r3_negvn;
    logic               r3_slop_ok, r3_vnneg, r3_dneg;
    logic               r4_slop_ok, r4_vnneg, r4_dneg;

    assign w3_vnr  = (r2_vn + 50'sd8192) >>> 14;
    assign w3_vn16 = w3_vnr[35:0];
    assign w3_neg  = -37'(w3_vn16);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_dn[i]  = r2_d * w_n[i];
            n3_vnn[i] = w3_vn16 * w_n[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_type    <= r2_type;
            r3_p       <= r2_p;
            r3_vel     <= r2_vel;
            r3_dn      <= n3_dn;
            r3_vnn     <= n3_vnn;
            r3_negvn   <= w3_neg[33:0];
            r3_slop_ok <= (r2_d <= (40'(i_cfg.slop) <<< 14));
            r3_vnneg   <= r2_vn[49];
            r3_dneg    <= r2_d[39];
        end
    end

    // stage 4: projection, tangent, friction product
    logic signed [57:0]    n4_q [3];
    logic signed [57:0]    r4_q [3];
    logic [2:0][VEL_W-1:0] n4_t, r4_t, r5_t, r6_t;
    logic [49:0]           r4_fcv;

    always_comb begin
        logic signed [52:0] diff;
        logic signed [52:0] rnd;
        for (int i = 0; i < 3; i++) begin
            n4_q[i] = (58'($signed(r3_p[i])) <<< 28) - 58'(r3_dn[i]);
            diff    = (53'($signed(r3_vel[i])) <<< 14) - 53'(r3_vnn[i]);
            rnd     = (diff + 53'sd8192) >>> 14;
            n4_t[i] = sat_vel(rnd[38:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_type    <= r3_type;
            r4_p       <= r3_p;
            r4_vel     <= r3_vel;
            r4_q       <= n4_q;
            r4_t       <= n4_t;
            r4_fcv     <= r3_negvn * i_cfg.fc;
            r4_slop_ok <= r3_slop_ok;
            r4_vnneg   <= r3_vnneg;
            r4_dneg    <= r3_dneg;
        end
    end

    // stage 5: region test, corrected position, tangent squares
    logic                  w5_in;
    logic [2:0][POS_W-1:0] n5_p;
    logic [62:0]           n5_sq [3];
    logic [62:0]           r5_sq [3];
    logic [DROP_W-1:0]     r5_drop, r6_drop;
    logic [49:0]           w5_fcr;
    logic                  r5_in, r5_contact, r6_in, r6_contact;
    logic [2:0][POS_W-1:0] r6_p;
    logic [SQ_W-1:0]       r6_sq;
    logic                  r6_zero;

    always_comb begin
        logic signed [57:0] qr;
        logic signed [63:0] sq;
        w5_in = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (i_cfg.region_en) begin
                if ((r4_q[i] + 58'sd1100 < w_lo[i]) || (r4_q[i] - 58'sd1100 > w_hi[i])) begin
                    w5_in = 1'b0;
                end
            end
            qr = (r4_q[i] + (58'sd1 <<< 27)) >>> 28;
            n5_p[i] = (r4_type && r4_dneg) ? sat_pos(qr[29:0]) : r4_p[i];
            sq = $signed(r4_t[i]) * $signed(r4_t[i]);
            n5_sq[i] = sq[62:0];
        end
    end

    assign w5_fcr = r4_fcv + 50'd2048;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_p       <= w5_in ? n5_p : r4_p;
            r5_vel     <= r4_vel;
            r5_t       <= r4_t;
            r5_sq      <= n5_sq;
            r5_drop    <= w5_fcr[49:12];
            r5_in      <= w5_in;
            r5_contact <= w5_in && r4_slop_ok && r4_vnneg;
        end
    end

    // stage 6: tangent length squared
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p       <= r5_p;
            r6_vel     <= r5_vel;
            r6_t       <= r5_t;
            r6_sq      <= 64'(r5_sq[0]) + 64'(r5_sq[1]) + 64'(r5_sq[2]);
            r6_zero    <= (r5_t[0] == '0) && (r5_t[1] == '0) && (r5_t[2] == '0);
            r6_drop    <= r5_drop;
            r6_in      <= r5_in;
            r6_contact <= r5_contact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    assign o_valid = r6_v;

    always_comb begin
        o_res         = '0;
        o_res.pos     = r6_p;
        o_res.vel     = r6_vel;
        o_res.tang    = r6_t;
        o_res.sq      = r6_sq;
        o_res.drop    = r6_drop;
        o_res.in_reg  = r6_in;
        o_res.contact = r6_contact;
        o_res.zero    = r6_zero;
    end

endmodule
`default_nettype wire

// File: hdl/pcf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_fifo
// small register queue between front and back
// ----------------------------------------------------------------------------
module pcf_fifo import pcf_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

// File: hdl/pcf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcf_back
// friction response: pipelined square root, scaling divide, output register
// ----------------------------------------------------------------------------
module pcf_back import pcf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_pop,
    input  wire t_front_res i_res,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [2:0][POS_W-1:0] o_pos,
    output logic [2:0][VEL_W-1:0] o_vel,
    output logic            o_in_reg,
    output logic            o_contact
);

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    logic w_en;
    logic r_out_v;

    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en && i_valid;
    assign o_valid = r_out_v;

    // square root, one result bit per stage
    logic [SQ_W-1:0]  r_sx   [SQRT_STEPS+1];
    logic [SQ_W-1:0]  r_sr   [SQRT_STEPS+1];
    logic             r_sv   [SQRT_STEPS+1];
    t_front_res       r_sres [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sx[0]   <= i_res.sq;
            r_sr[0]   <= '0;
            r_sres[0] <= i_res;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = 64'd1 << (62 - 2*j);
        logic [SQ_W-1:0] w_trial;
        assign w_trial = r_sr[j] + BIT;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sres[j+1] <= r_sres[j];
                if (r_sx[j] >= w_trial) begin
                    r_sx[j+1] <= r_sx[j] - w_trial;
                    r_sr[j+1] <= (r_sr[j] >> 1) + BIT;
                end else begin
                    r_sx[j+1] <= r_sx[j];
                    r_sr[j+1] <= r_sr[j] >> 1;
                end
            end
        end
    end

    // reduced speed and tangent magnitudes
    logic [SPD_W-1:0]      w_speed;
    logic [SPD_W-1:0]      r_m_ns, r_m_speed;
    logic [VEL_W-1:0]      r_m_mag [3];
    t_front_res            r_m_res;
    logic                  r_m_v;

    assign w_speed = r_sr[SQRT_STEPS][SPD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_speed <= w_speed;
            r_m_ns    <= (40'(w_speed) > 40'(r_sres[SQRT_STEPS].drop))
                       ? w_speed - r_sres[SQRT_STEPS].drop[SPD_W-1:0] : '0;
            for (int i = 0; i < 3; i++) begin
                r_m_mag[i] <= r_sres[SQRT_STEPS].tang[i][VEL_W-1]
                            ? (~r_sres[SQRT_STEPS].tang[i] + 1'b1)
                            : r_sres[SQRT_STEPS].tang[i];
            end
            r_m_res <= r_sres[SQRT_STEPS];
        end
    end

    // scaling divide |t| * ns / speed, one quotient bit per stage
    logic [SPD_W-1:0] r_drem [DIV_STEPS+1][3];
    logic [SPD_W-1:0] r_dlow [DIV_STEPS+1][3];
    logic [SPD_W-1:0] r_dq   [DIV_STEPS+1][3];
    logic [SPD_W-1:0] r_dd   [DIV_STEPS+1];
    t_front_res       r_dres [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        logic [63:0] prod;
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                prod          = 64'(r_m_mag[i]) * 64'(r_m_ns);
                r_drem[0][i] <= prod[63:32];
                r_dlow[0][i] <= prod[31:0];
                r_dq[0][i]   <= '0;
            end
            r_dd[0]   <= r_m_speed;
            r_dres[0] <= r_m_res;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [SPD_W:0] tmp;
            logic           ge;
            if (w_en) begin
                for (int i = 0; i < 3; i++) begin
                    tmp = {r_drem[j][i], r_dlow[j][i][SPD_W-1]};
                    ge  = (tmp >= {1'b0, r_dd[j]});
                    r_drem[j+1][i] <= ge ? 32'(tmp - {1'b0, r_dd[j]}) : tmp[SPD_W-1:0];
                    r_dlow[j+1][i] <= r_dlow[j][i] << 1;
                    r_dq[j+1][i]   <= {r_dq[j][i][SPD_W-2:0], ge};
                end
                r_dd[j+1]   <= r_dd[j];
                r_dres[j+1] <= r_dres[j];
            end
        end
    end

    // output register
    t_front_res w_fin;
    assign w_fin = r_dres[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        logic signed [32:0] sv;
        if (w_en) begin
            o_pos     <= w_fin.pos;
            o_in_reg  <= w_fin.in_reg;
            o_contact <= w_fin.contact;
            for (int i = 0; i < 3; i++) begin
                sv = w_fin.tang[i][VEL_W-1] ? -$signed({1'b0, r_dq[DIV_STEPS][i]})
                                            : $signed({1'b0, r_dq[DIV_STEPS][i]});
                if (!w_fin.contact) begin
                    o_vel[i] <= w_fin.vel[i];
                end else if (w_fin.zero) begin
                    o_vel[i] <= '0;
                end else begin
                    o_vel[i] <= sat_vel(39'(sv));
                end
            end
        end
    end

    // valid chain
    logic r_sv_chain [SQRT_STEPS+1];
    logic r_dv       [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_sv_chain[k] <= 1'b0;
            end
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_sv_chain[0] <= i_valid;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                r_sv_chain[k] <= r_sv_chain[k-1];
            end
            r_m_v   <= r_sv_chain[SQRT_STEPS];
            r_dv[0] <= r_m_v;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_out_v <= r_dv[DIV_STEPS];
        end
    end

    assign r_sv[0] = r_sv_chain[0];
    for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sv
        assign r_sv[k] = r_sv_chain[k];
    end

    a_contact_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv[SQRT_STEPS] && r_sres[SQRT_STEPS].contact |-> r_sres[SQRT_STEPS].in_reg)
        else $error("contact outside region");

endmodule
`default_nettype wire

// File: hdl/plane_collider_friction_contact_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plane_collider_friction_contact_core
// plane collider with optional box region and coulomb friction response
// ----------------------------------------------------------------------------
// path from input request to output valid, in order:
//   6 front stages, queue, 33 square-root stages, 2 scale stages,
//   32 divide stages, output register
// throughput: one request per cycle; the pipelines hold on back pressure
// reset: synchronous active-low, clears all valid bits, queue pointers and
//   restores the configuration registers to their reset values
// ----------------------------------------------------------------------------
module plane_collider_friction_contact_core import pcf_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input request stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, zero pad
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    // req_type
    input  wire logic [0:0]            s_axis_tuser,
    // result stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, zero pad
    output logic [TDATA_W-1:0]         m_axis_tdata,
    // in_region, contact_applied
    output logic [1:0]                 m_axis_tuser
);

    // configuration registers: user must write only while core idle; unenforced
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{normal: 48'd16384, default: '0};
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_NORMAL:   r_cfg.normal    <= i_cfg_data[47:0];
                CFG_OFFSET:   r_cfg.offset    <= i_cfg_data[POS_W-1:0];
                CFG_FRICTION: r_cfg.fc        <= i_cfg_data[FC_W-1:0];
                CFG_REGION:   r_cfg.region_en <= i_cfg_data[0];
                CFG_LOW:      r_cfg.low       <= i_cfg_data[62:0];
                CFG_HIGH:     r_cfg.high      <= i_cfg_data[62:0];
                CFG_SLOP:     r_cfg.slop      <= i_cfg_data[POS_W-1:0];
                default:      r_cfg           <= r_cfg;
            endcase
        end
    end

    // unpack the request payload
    logic [2:0][POS_W-1:0] w_pos;
    logic [2:0][VEL_W-1:0] w_vel;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = s_axis_tdata[POS_W*i +: POS_W];
            w_vel[i] = s_axis_tdata[3*POS_W + VEL_W*i +: VEL_W];
        end
    end

    // front: distance, projection, region and tangent
    logic       w_f_valid, w_q_full, w_q_empty, w_pop, w_push;
    t_front_res w_f_res, w_q_res;

    pcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_type  (s_axis_tuser[0]),
        .i_pos   (w_pos),
        .i_vel   (w_vel),
        .o_valid (w_f_valid),
        .i_ready (!w_q_full),
        .o_res   (w_f_res)
    );

    assign w_push = w_f_valid && !w_q_full;

    // decoupling queue, lets the friction pipeline stall on its own
    pcf_fifo #(
        .WIDTH ($bits(t_front_res)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_res),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_data  (w_q_res),
        .o_empty (w_q_empty)
    );

    // back: tangent speed, friction drop and rescale
    logic [2:0][POS_W-1:0] w_o_pos;
    logic [2:0][VEL_W-1:0] w_o_vel;
    logic                  w_o_in, w_o_contact;

    pcf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (!w_q_empty),
        .o_pop     (w_pop),
        .i_res     (w_q_res),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pos     (w_o_pos),
        .o_vel     (w_o_vel),
        .o_in_reg  (w_o_in),
        .o_contact (w_o_contact)
    );

    // pack the result payload
    assign m_axis_tdata = {1'b0, w_o_vel, w_o_pos};
    assign m_axis_tuser = {w_o_contact, w_o_in};

    a_out_contact_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
        else $error("result reports contact outside region");

    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (w_f_valid && w_q_full))
        else $error("front stalled without a full queue");

endmodule
`default_nettype wire
